// ===== rtl/gqrs_pkg.sv =====
// Shared constants, codes and types for the greedy Q-table radius selector.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package gqrs_pkg;

   // Field widths of the channels
   localparam int DIST_W        = 21;
   localparam int DIST_MAG_W    = 20;
   localparam int RADIUS_W      = 16;
   localparam int SPAN_W        = 17;
   localparam int ACT_COUNT_W   = 5;
   localparam int STATE_COUNT_W = 8;
   localparam int ACTION_W      = 4;
   localparam int Q_W           = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   // Register reset values
   localparam logic [RADIUS_W-1:0]      RESET_MAX_RADIUS   = 16'd8000;
   localparam logic [ACT_COUNT_W-1:0]   RESET_ACTION_COUNT = 5'd10;
   localparam logic [STATE_COUNT_W-1:0] RESET_STATE_COUNT  = 8'd100;

   // Q value limits, units of 0.01
   localparam logic signed [Q_W-1:0] Q_CAP   = 16'sd100;
   localparam logic signed [Q_W-1:0] Q_FLOOR = 16'sh8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_RADIUS   = 2'd0,
      CSR_ACTION_COUNT = 2'd1,
      CSR_STATE_COUNT  = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_QUERY  = 1'b0,
      FUNC_UPDATE = 1'b1
   } func_type;

   typedef enum logic {
      STATUS_OK     = 1'b0,
      STATUS_REJECT = 1'b1
   } status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/gqrs_if.sv =====
// Valid/ready channel interfaces: request, response and register write.
// Depends on gqrs_pkg for field widths.
interface gqrs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic signed [gqrs_pkg::DIST_W-1:0]  distance;
   logic                                route_found;

   modport source (output valid, func, distance, route_found, input ready);
   modport sink   (input valid, func, distance, route_found, output ready);
endinterface

interface gqrs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                status;
   logic [gqrs_pkg::ACTION_W-1:0]       action_index;
   logic [gqrs_pkg::RADIUS_W-1:0]       radius;
   logic signed [gqrs_pkg::Q_W-1:0]     q_value;

   modport source (output valid, status, action_index, radius, q_value, input ready);
   modport sink   (input valid, status, action_index, radius, q_value, output ready);
endinterface

interface gqrs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gqrs_pkg::CSR_INDEX_W-1:0]    index;
   logic [gqrs_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/greedy_q_table_radius_select.sv =====
// Top level of the greedy Q-table radius selector: sequencer, registers, result stage.
// Depends on gqrs_pkg, gqrs_if, gqrs_qmem and gqrs_div.
//
//  channel  dir  payload                                  word accepted when
//  req_ch   in   func, distance, route_found              valid && ready
//  rsp_ch   out  status, action_index, radius, q_value    valid && ready
//  csr_ch   in   index, data                              valid && ready (always ready)
//
// After reset a clearing pass writes 100 into every Q entry, one entry a cycle, over all
// MAX_STATES*MAX_ACTIONS entries (2048 by default); req_ch.ready stays low meanwhile.
// A rejected word (negative distance) goes straight to the result stage. Otherwise the
// serial divider (28 bits wide by default) runs once for the state and once for the
// radius, and the row scan reads one entry per cycle through the single memory read
// port. A distance at or beyond the span skips the state division.
// The result register lets the next word be accepted while a response stalls.
module greedy_q_table_radius_select #(
   parameter int MAX_ACTIONS = 16,
   parameter int MAX_STATES  = 128
) (
   input  logic       clock,
   input  logic       reset,
   gqrs_req_if.sink   req_ch,
   gqrs_rsp_if.source rsp_ch,
   gqrs_csr_if.sink   csr_ch
);

   localparam int DEPTH  = MAX_STATES * MAX_ACTIONS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SIW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int AIW    = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
   localparam int SCW    = $clog2(MAX_STATES + 1);
   localparam int ACW    = $clog2(MAX_ACTIONS + 1);
   localparam int NUM1_W = gqrs_pkg::DIST_MAG_W + SCW;
   localparam int NUM2_W = gqrs_pkg::RADIUS_W + ACW;
   localparam int DIV_NW = (NUM1_W > NUM2_W) ? NUM1_W : NUM2_W;
   localparam int DIV_DW = gqrs_pkg::SPAN_W;
   localparam int QW     = gqrs_pkg::Q_W;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SDIV  = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_UPD   = 7'b0010000,
      S_RDIV  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // ---------------------------------------------------------------- registers
   logic [gqrs_pkg::RADIUS_W-1:0]      max_radius_ff;
   logic [gqrs_pkg::ACT_COUNT_W-1:0]   action_count_ff;
   logic [gqrs_pkg::STATE_COUNT_W-1:0] state_count_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_radius_ff   <= gqrs_pkg::RESET_MAX_RADIUS;
         action_count_ff <= gqrs_pkg::RESET_ACTION_COUNT;
         state_count_ff  <= gqrs_pkg::RESET_STATE_COUNT;
      end else if (csr_ch.valid && csr_ch.ready) begin
         // drop writes to an index beyond the register list
         case (csr_ch.index)
            gqrs_pkg::CSR_MAX_RADIUS:   max_radius_ff   <= csr_ch.data;
            gqrs_pkg::CSR_ACTION_COUNT: action_count_ff <= csr_ch.data[gqrs_pkg::ACT_COUNT_W-1:0];
            gqrs_pkg::CSR_STATE_COUNT:  state_count_ff  <= csr_ch.data[gqrs_pkg::STATE_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry: clamp the raw registers into the usable range
   logic [gqrs_pkg::RADIUS_W-1:0] eff_radius;
   logic [gqrs_pkg::SPAN_W-1:0]   span;
   logic [ACW-1:0]                eff_actions;
   logic [SCW-1:0]                eff_states;

   always_comb begin
      eff_radius = (max_radius_ff == '0) ? gqrs_pkg::RADIUS_W'(1) : max_radius_ff;
      span       = {eff_radius, 1'b0};
      if (action_count_ff == '0) begin
         eff_actions = ACW'(1);
      end else if (32'(action_count_ff) > MAX_ACTIONS) begin
         eff_actions = ACW'(MAX_ACTIONS);
      end else begin
         eff_actions = ACW'(action_count_ff);
      end
      if (state_count_ff == '0) begin
         eff_states = SCW'(1);
      end else if (32'(state_count_ff) > MAX_STATES) begin
         eff_states = SCW'(MAX_STATES);
      end else begin
         eff_states = SCW'(state_count_ff);
      end
   end

   // ---------------------------------------------------------------- sequencer state
   state_type state_ff, state_in;
   logic [AW-1:0]                 clr_addr_ff, clr_addr_in;
   logic [SIW-1:0]                st_ff, st_in;
   logic [ACW-1:0]                issue_ff, issue_in;
   logic                          pend_ff, pend_in;
   logic [AIW-1:0]                pend_idx_ff, pend_idx_in;
   logic [AIW-1:0]                best_idx_ff, best_idx_in;
   logic signed [QW-1:0]          best_q_ff, best_q_in;
   logic                          func_ff, func_in;
   logic                          found_ff, found_in;
   logic                          status_res_ff, status_res_in;
   logic signed [QW-1:0]          q_res_ff, q_res_in;
   logic [gqrs_pkg::RADIUS_W-1:0] radius_res_ff, radius_res_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;
   logic                          rsp_status_ff;
   logic [gqrs_pkg::ACTION_W-1:0] rsp_action_ff;
   logic [gqrs_pkg::RADIUS_W-1:0] rsp_radius_ff;
   logic signed [QW-1:0]          rsp_q_ff;

   // ---------------------------------------------------------------- memory and divider
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic signed [QW-1:0]  mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic signed [QW-1:0]  mem_rdata;

   logic                  div_start;
   logic [DIV_NW-1:0]     div_dividend;
   logic [DIV_DW-1:0]     div_divisor;
   logic [DIV_NW-1:0]     div_quotient;
   gqrs_pkg::div_stat_type div_stat;

   gqrs_qmem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_qmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   gqrs_div #(
      .NW (DIV_NW),
      .DW (DIV_DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // ---------------------------------------------------------------- address and update
   logic [AW:0]                     base_full;
   logic [AW-1:0]                   row_base;
   logic [AW-1:0]                   scan_addr;
   logic [AW-1:0]                   best_addr;
   logic [gqrs_pkg::DIST_MAG_W-1:0] dist_mag;
   logic                            req_fire;
   logic signed [QW:0]              q_sum;
   logic signed [QW-1:0]            q_new;

   always_comb begin
      base_full = (AW+1)'(st_ff) * (AW+1)'(MAX_ACTIONS);
      row_base  = base_full[AW-1:0];
      scan_addr = row_base + AW'(issue_ff);
      best_addr = row_base + AW'(best_idx_ff);
      dist_mag  = req_ch.distance[gqrs_pkg::DIST_MAG_W-1:0];
      req_fire  = req_ch.valid && req_ch.ready;

      // +1 capped at 1.0, or -1 saturated at the floor
      if (found_ff) begin
         q_sum = {best_q_ff[QW-1], best_q_ff} + (QW+1)'(1);
         q_new = (q_sum > (QW+1)'(signed'(gqrs_pkg::Q_CAP))) ? gqrs_pkg::Q_CAP : q_sum[QW-1:0];
      end else begin
         q_sum = {best_q_ff[QW-1], best_q_ff} - (QW+1)'(1);
         q_new = (q_sum < (QW+1)'(signed'(gqrs_pkg::Q_FLOOR))) ? gqrs_pkg::Q_FLOOR
                                                                 : q_sum[QW-1:0];
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      st_in         = st_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      best_idx_in   = best_idx_ff;
      best_q_in     = best_q_ff;
      func_in       = func_ff;
      found_in      = found_ff;
      status_res_in = status_res_ff;
      q_res_in      = q_res_ff;
      radius_res_in = radius_res_ff;

      mem_we       = 1'b0;
      mem_waddr    = best_addr;
      mem_wdata    = q_new;
      mem_raddr    = scan_addr;
      div_start    = 1'b0;
      div_dividend = DIV_NW'(NUM1_W'(dist_mag) * NUM1_W'(eff_states));
      div_divisor  = span;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the store to its reset value
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = gqrs_pkg::Q_CAP;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               func_in  = req_ch.func;
               found_in = req_ch.route_found;
               issue_in = '0;
               if (req_ch.distance[gqrs_pkg::DIST_W-1]) begin
                  // reject: leave the store untouched, report zeros
                  status_res_in = gqrs_pkg::STATUS_REJECT;
                  best_idx_in   = '0;
                  q_res_in      = '0;
                  radius_res_in = '0;
                  state_in      = S_DONE;
               end else begin
                  status_res_in = gqrs_pkg::STATUS_OK;
                  if (dist_mag >= gqrs_pkg::DIST_MAG_W'(span)) begin
                     st_in    = SIW'(eff_states - 1'b1);
                     state_in = S_SCAN;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_SDIV;
                  end
               end
            end
         end
         S_SDIV: begin
            if (div_stat.done) begin
               // quotient is below the state count, so it fits the state index
               st_in    = div_quotient[SIW-1:0];
               issue_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read a cycle, compare the entry returned in the following cycle
            if (issue_ff < eff_actions) begin
               pend_in     = 1'b1;
               pend_idx_in = AIW'(issue_ff);
               issue_in    = issue_ff + 1'b1;
            end
            if (pend_ff) begin
               if (pend_idx_ff == '0 || mem_rdata > best_q_ff) begin
                  best_idx_in = pend_idx_ff;
                  best_q_in   = mem_rdata;
               end
               if (ACW'(pend_idx_ff) == eff_actions - 1'b1) begin
                  pend_in  = 1'b0;
                  state_in = S_UPD;
               end
            end
         end
         S_UPD: begin
            // on an update, write back the winning entry; the next word reads the row only
            // after this cycle, so no forwarding path is needed
            mem_we       = (func_ff == gqrs_pkg::FUNC_UPDATE);
            q_res_in     = (func_ff == gqrs_pkg::FUNC_UPDATE) ? q_new : best_q_ff;
            div_start    = 1'b1;
            div_dividend = DIV_NW'(NUM2_W'(ACW'(best_idx_ff) + 1'b1) * NUM2_W'(eff_radius));
            div_divisor  = DIV_DW'(eff_actions);
            state_in     = S_RDIV;
         end
         S_RDIV: begin
            if (div_stat.done) begin
               radius_res_in = div_quotient[gqrs_pkg::RADIUS_W-1:0];
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff         <= st_in;
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_q_ff     <= best_q_in;
      func_ff       <= func_in;
      found_ff      <= found_in;
      status_res_ff <= status_res_in;
      q_res_ff      <= q_res_in;
      radius_res_ff <= radius_res_in;
      if (rsp_load) begin
         rsp_status_ff <= status_res_ff;
         rsp_action_ff <= gqrs_pkg::ACTION_W'(best_idx_ff);
         rsp_radius_ff <= radius_res_ff;
         rsp_q_ff      <= q_res_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.action_index = rsp_action_ff;
   assign rsp_ch.radius       = rsp_radius_ff;
   assign rsp_ch.q_value      = rsp_q_ff;

   // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
   a_reject_to_done: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.distance[gqrs_pkg::DIST_W-1]) |=> state_ff == S_DONE)
      else $error("rejected word did not go straight to the result stage");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_SDIV || state_ff == S_RDIV))
      else $error("divider finished while nothing waited for it");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the result stage");

   a_update_capped: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == S_UPD) |-> mem_wdata <= gqrs_pkg::Q_CAP)
      else $error("Q write-back above the cap");

   a_scan_in_row: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (ACW'(pend_idx_ff) < eff_actions && $past(state_ff == S_SCAN)))
      else $error("scan read outside the active part of the row");
`endif

endmodule

// ===== rtl/gqrs_qmem.sv =====
// Q value store: one write port, one read port with registered read data.
// Depends on gqrs_pkg for the entry width.
module gqrs_qmem #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [AW-1:0]                    waddr,
   input  logic signed [gqrs_pkg::Q_W-1:0]  wdata,
   input  logic [AW-1:0]                    raddr,
   output logic signed [gqrs_pkg::Q_W-1:0]  rdata
);

   logic signed [gqrs_pkg::Q_W-1:0] mem [DEPTH];
   logic signed [gqrs_pkg::Q_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/gqrs_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on gqrs_pkg for the status struct.
module gqrs_div #(
   parameter int NW = 28,
   parameter int DW = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NW-1:0]         dividend,
   input  logic [DW-1:0]         divisor,
   output logic [NW-1:0]         quotient,
   output gqrs_pkg::div_stat_type stat
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] work_ff, work_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] divisor_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, work_ff[NW-1]};
      ge      = trial >= {1'b0, divisor_ff};
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract where it fits
         work_in = {work_ff[NW-2:0], ge};
         rem_in  = ge ? DW'(trial - {1'b0, divisor_ff}) : trial[DW-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign quotient  = work_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
